@@ rtl/evr_pkg.sv @@
package evr_pkg;

  localparam int SINE_ENTRIES_DEF = 1024;

  localparam int VEC_W  = 16;
  localparam int ANG_W  = 16;
  localparam int COEF_W = 17;
  localparam int OUT_W  = 17;
  localparam int PROD_W = 48;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [2:0][2:0] mat_t;

  // Rounded quarter-wave sine sample k, scaled by 32768. The step is the angle in
  // radians between two neighboring samples.
  function automatic logic [16:0] sine_sample(int k, real step);
    real x;
    int  v;
    x = step * k;
    v = $rtoi($sin(x) * 32768.0 + 0.5);
    if (v > 32768) v = 32768;
    return 17'(v);
  endfunction

  // Round a value at scale 2^-45 to 2^-15 (half up) and clamp to [-1, 1].
  function automatic coef_t round_q30(logic signed [48:0] v);
    logic signed [49:0] t;
    logic signed [49:0] q;
    t = 50'(v) + 50'sd536870912;
    q = t >>> 30;
    if (q < -50'sd32768) return -17'sd32768;
    if (q > 50'sd32768) return 17'sd32768;
    return q[16:0];
  endfunction

  // Same for a value at scale 2^-30 produced by one pair product.
  function automatic coef_t round_q15(logic signed [48:0] v);
    logic signed [49:0] t;
    logic signed [49:0] q;
    t = 50'(v) + 50'sd16384;
    q = t >>> 15;
    if (q < -50'sd32768) return -17'sd32768;
    if (q > 50'sd32768) return 17'sd32768;
    return q[16:0];
  endfunction

endpackage

@@ rtl/evr_matrix.sv @@
module evr_matrix import evr_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [ANG_W-1:0] cfg_data,
  output mat_t             mat,
  output logic             mat_ready
);

  localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam real SINE_STEP = 1.5707963267948966 / SINE_TABLE_ENTRIES;

  typedef logic [16:0] rom_t [0:SINE_TABLE_ENTRIES];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      r[k] = sine_sample(k, SINE_STEP);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  typedef enum logic [3:0] {
    ST_LOOK = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ENT  = 4'b0100,
    ST_RDY  = 4'b1000
  } state_t;

  localparam logic [3:0] LOOK_LAST = 4'd5;
  localparam logic [3:0] MUL_LAST  = 4'd13;

  state_t               state_r, state_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [ANG_W-1:0]     ang_r [3];
  coef_t                trig_r [6];
  logic signed [PROD_W-1:0] prod_r [14];
  mat_t                 mat_r;

  // Sine lookup for the angle selected by the step counter.
  logic [ANG_W-1:0]     ang_sel;
  logic [ANG_W-1:0]     ang_eff;
  logic [14+IW-1:0]     scaled;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        ridx;
  logic [16:0]          mag;
  coef_t                trig_val;

  always_comb begin
    case (cnt_r[2:1])
      2'd0:    ang_sel = ang_r[0];
      2'd1:    ang_sel = ang_r[1];
      2'd2:    ang_sel = ang_r[2];
      default: ang_sel = ang_r[0];
    endcase
    ang_eff  = ang_sel + (cnt_r[0] ? 16'h4000 : 16'h0000);
    scaled   = (14+IW)'(ang_eff[13:0]) * (14+IW)'(SINE_TABLE_ENTRIES);
    idx      = scaled[14 +: IW];
    ridx     = IW'(SINE_TABLE_ENTRIES) - idx;
    mag      = ang_eff[14] ? SINE_ROM[ridx] : SINE_ROM[idx];
    trig_val = ang_eff[15] ? -$signed(mag) : $signed(mag);
  end

  // One shared multiplier; trig_r holds s1, c1, s2, c2, s3, c3 in that order.
  coef_t                    op_a;
  logic signed [34:0]       op_b;
  logic signed [51:0]       prod_w;

  always_comb begin
    case (cnt_r)
      4'd0:    begin op_a = trig_r[3]; op_b = 35'(trig_r[5]); end
      4'd1:    begin op_a = trig_r[3]; op_b = 35'(trig_r[4]); end
      4'd2:    begin op_a = trig_r[0]; op_b = 35'(trig_r[4]); end
      4'd3:    begin op_a = trig_r[1]; op_b = 35'(trig_r[4]); end
      4'd4:    begin op_a = trig_r[0]; op_b = 35'(trig_r[5]); end
      4'd5:    begin op_a = trig_r[1]; op_b = 35'(trig_r[5]); end
      4'd6:    begin op_a = trig_r[2]; op_b = 35'(trig_r[5]); end
      4'd7:    begin op_a = trig_r[2]; op_b = 35'(trig_r[4]); end
      4'd8:    begin op_a = trig_r[1]; op_b = 35'(trig_r[2]); end
      4'd9:    begin op_a = trig_r[0]; op_b = 35'(trig_r[2]); end
      4'd10:   begin op_a = trig_r[1]; op_b = prod_r[0][34:0]; end
      4'd11:   begin op_a = trig_r[0]; op_b = prod_r[0][34:0]; end
      4'd12:   begin op_a = trig_r[1]; op_b = prod_r[1][34:0]; end
      4'd13:   begin op_a = trig_r[0]; op_b = prod_r[1][34:0]; end
      default: begin op_a = trig_r[0]; op_b = 35'(trig_r[0]); end
    endcase
    prod_w = 52'(op_a) * 52'(op_b);
  end

  mat_t mat_nxt;

  always_comb begin
    mat_nxt[0][0] = round_q30(49'(prod_r[10]) - (49'(prod_r[2]) <<< 15));
    mat_nxt[0][1] = round_q30(49'(prod_r[11]) + (49'(prod_r[3]) <<< 15));
    mat_nxt[0][2] = round_q15(-49'(prod_r[6]));
    mat_nxt[1][0] = round_q30(-49'(prod_r[12]) - (49'(prod_r[4]) <<< 15));
    mat_nxt[1][1] = round_q30(-49'(prod_r[13]) + (49'(prod_r[5]) <<< 15));
    mat_nxt[1][2] = round_q15(49'(prod_r[7]));
    mat_nxt[2][0] = round_q15(49'(prod_r[8]));
    mat_nxt[2][1] = round_q15(49'(prod_r[9]));
    mat_nxt[2][2] = trig_r[3];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 4'd1;
    case (state_r)
      ST_LOOK: if (cnt_r == LOOK_LAST) begin
        state_nxt = ST_MUL;
        cnt_nxt   = '0;
      end
      ST_MUL: if (cnt_r == MUL_LAST) begin
        state_nxt = ST_ENT;
        cnt_nxt   = '0;
      end
      ST_ENT: begin
        state_nxt = ST_RDY;
        cnt_nxt   = '0;
      end
      ST_RDY: cnt_nxt = '0;
      default: begin
        state_nxt = ST_LOOK;
        cnt_nxt   = '0;
      end
    endcase
    // A new angle restarts the whole build.
    if (cfg_we) begin
      state_nxt = ST_LOOK;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOOK;
      cnt_r   <= '0;
      ang_r[0] <= '0;
      ang_r[1] <= '0;
      ang_r[2] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          2'd0:    ang_r[0] <= cfg_data;
          2'd1:    ang_r[1] <= cfg_data;
          2'd2:    ang_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) trig_r[cnt_r[2:0]] <= trig_val;
    if (state_r == ST_MUL) prod_r[cnt_r] <= prod_w[PROD_W-1:0];
    if (state_r == ST_ENT) mat_r <= mat_nxt;
  end

  assign mat       = mat_r;
  assign mat_ready = (state_r == ST_RDY);

endmodule

@@ rtl/evr_datapath.sv @@
module evr_datapath import evr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mat_t                    mat,
  input  logic                    mat_ready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic signed [VEC_W-1:0] in_vec_x,
  input  logic signed [VEC_W-1:0] in_vec_y,
  input  logic signed [VEC_W-1:0] in_vec_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_x,
  output logic signed [OUT_W-1:0] out_y,
  output logic signed [OUT_W-1:0] out_z
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  logic                    cmd1_r;
  logic signed [VEC_W-1:0] vec1_r [3];
  logic signed [32:0]      p2_r [3][3];
  logic signed [34:0]      s3_r [3];
  logic signed [OUT_W-1:0] o4_r [3];

  assign rdy4   = !v4_r || !out_stall;
  assign rdy3   = !v3_r || rdy4;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign in_stall = !(rdy1 && mat_ready);
  assign accept = in_valid && !in_stall;

  // Backward rotation reads the matrix transposed.
  logic signed [32:0] p_nxt [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_nxt[r][c] = 33'($signed(cmd1_r ? mat[c][r] : mat[r][c])) * 33'(vec1_r[c]);
      end
    end
  end

  logic signed [34:0]      s_nxt [3];
  logic signed [OUT_W-1:0] o_nxt [3];
  always_comb begin
    logic signed [35:0] t;
    logic signed [35:0] q;
    for (int r = 0; r < 3; r++) begin
      s_nxt[r] = 35'(p2_r[r][0]) + 35'(p2_r[r][1]) + 35'(p2_r[r][2]);
    end
    for (int r = 0; r < 3; r++) begin
      t = 36'(s3_r[r]) + 36'sd16384;
      q = t >>> 15;
      if (q < -36'sd65536)     o_nxt[r] = -17'sd65536;
      else if (q > 36'sd65535) o_nxt[r] = 17'sd65535;
      else                     o_nxt[r] = q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= accept;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd1_r    <= in_command;
      vec1_r[0] <= in_vec_x;
      vec1_r[1] <= in_vec_y;
      vec1_r[2] <= in_vec_z;
    end
    if (v1_r && rdy2) p2_r <= p_nxt;
    if (v2_r && rdy3) s3_r <= s_nxt;
    if (v3_r && rdy4) o4_r <= o_nxt;
  end

  assign out_valid = v4_r;
  assign out_x     = o4_r[0];
  assign out_y     = o4_r[1];
  assign out_z     = o4_r[2];

endmodule

@@ rtl/euler_angle_vector_rotation.sv @@
// Z-Y-Z Euler rotation of a 3D vector in fixed point.
// The three angles are written over the cfg_ channel (index 0, 1, 2; other
// indexes are dropped). cfg_ready is always high. Each write, and reset,
// starts a rebuild of the rotation matrix on one shared multiplier;
// in_stall stays high until it is done.
// Input beats carry a command (0 forward, 1 transposed) and a Q2.14 vector.
// Output beats carry the Q3.14 result, rounded and saturated.
// The vector pipeline has four register stages; one beat per cycle is sustained
// while out_stall is low and the matrix is ready. When out_stall is high, the
// last stage holds its beat and earlier stages keep filling empty slots;
// in_stall rises only once the pipeline is full or while the matrix is rebuilt.
// Reset empties the pipeline and clears the angles to zero.
module euler_angle_vector_rotation import evr_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [ANG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic signed [VEC_W-1:0] in_vec_x,
  input  logic signed [VEC_W-1:0] in_vec_y,
  input  logic signed [VEC_W-1:0] in_vec_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_x,
  output logic signed [OUT_W-1:0] out_y,
  output logic signed [OUT_W-1:0] out_z
);

  mat_t mat;
  logic mat_ready;

  assign cfg_ready = 1'b1;

  evr_matrix #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat),
    .mat_ready (mat_ready)
  );

  evr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .mat        (mat),
    .mat_ready  (mat_ready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_vec_x   (in_vec_x),
    .in_vec_y   (in_vec_y),
    .in_vec_z   (in_vec_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z)
  );

endmodule

@@ tb/tb.sv @@
`default_nettype none
module tb;
  import evr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SINE = 1024;

  typedef enum bit {CMD_FORWARD = 1'b0, CMD_BACKWARD = 1'b1} cmd_e;
  typedef enum logic [1:0] {
    REG_ANGLE_FIRST = 2'd0, REG_ANGLE_SECOND = 2'd1, REG_ANGLE_THIRD = 2'd2,
    REG_UNUSED = 2'd3
  } reg_e;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } rotated_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [ANG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic signed [VEC_W-1:0] in_vec_x = '0;
  logic signed [VEC_W-1:0] in_vec_y = '0;
  logic signed [VEC_W-1:0] in_vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic signed [OUT_W-1:0] out_z;

  // Predictor state: angles, quarter-wave table and the rounded matrix.
  logic [15:0] angle_reg [3];
  int          quarter_sine [N_SINE+1];
  longint      rot_mat [3][3];

  rotated_t rotated_q [$];
  int       mismatches = 0;
  bit       quiet = 1'b0;
  bit       hold_req = 1'b0;

  always #4 clk = ~clk;

  euler_angle_vector_rotation u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z)
  );

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sine_of(logic [15:0] a);
    int     idx;
    longint v;
    idx = int'(a[13:0]) * N_SINE >> 14;
    v = a[14] ? quarter_sine[N_SINE - idx] : quarter_sine[idx];
    return a[15] ? -v : v;
  endfunction

  function automatic longint triple_entry(longint triple, longint pair);
    return clip(round_shift(triple + pair * 32768, 30), -32768, 32768);
  endfunction

  function automatic longint pair_entry(longint p);
    return clip(round_shift(p, 15), -32768, 32768);
  endfunction

  task automatic rebuild_matrix();
    longint s1, c1, s2, c2, s3, c3;
    s1 = sine_of(angle_reg[0]); c1 = sine_of(angle_reg[0] + 16'h4000);
    s2 = sine_of(angle_reg[1]); c2 = sine_of(angle_reg[1] + 16'h4000);
    s3 = sine_of(angle_reg[2]); c3 = sine_of(angle_reg[2] + 16'h4000);
    rot_mat[0][0] = triple_entry(c1 * c2 * c3, -s1 * s3);
    rot_mat[0][1] = triple_entry(s1 * c2 * c3, c1 * s3);
    rot_mat[0][2] = pair_entry(-s2 * c3);
    rot_mat[1][0] = triple_entry(-c1 * c2 * s3, -s1 * c3);
    rot_mat[1][1] = triple_entry(-s1 * c2 * s3, c1 * c3);
    rot_mat[1][2] = pair_entry(s2 * s3);
    rot_mat[2][0] = pair_entry(c1 * s2);
    rot_mat[2][1] = pair_entry(s1 * s2);
    rot_mat[2][2] = c2;
  endtask

  function automatic rotated_t rotate_vector(cmd_e cmd, logic signed [15:0] x,
                                              logic signed [15:0] y,
                                              logic signed [15:0] z);
    longint   v [3];
    longint   acc;
    longint   o [3];
    rotated_t r;
    v[0] = x; v[1] = y; v[2] = z;
    for (int row = 0; row < 3; row++) begin
      acc = 0;
      for (int col = 0; col < 3; col++) begin
        acc += (cmd == CMD_BACKWARD ? rot_mat[col][row] : rot_mat[row][col]) * v[col];
      end
      o[row] = clip(round_shift(acc, 15), -65536, 65535);
    end
    r.x = o[0][16:0]; r.y = o[1][16:0]; r.z = o[2][16:0];
    return r;
  endfunction

  task automatic report(string what, logic signed [OUT_W-1:0] got,
                        logic signed [OUT_W-1:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Result checker: every beat that leaves the block is matched in order.
  always @(posedge clk) begin
    rotated_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        mismatches++;
      end else begin
        want = rotated_q.pop_front();
        if (out_x !== want.x) report("out_x", out_x, want.x);
        if (out_y !== want.y) report("out_y", out_y, want.y);
        if (out_z !== want.z) report("out_z", out_z, want.z);
      end
    end
  end

  // Receiver back-pressure in random bursts, with one long hold on request.
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  task automatic send_vector(cmd_e cmd, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit may_idle = 1'b1);
    if (!in_valid) in_valid <= 1'b1;
    in_command <= cmd;
    in_vec_x <= x;
    in_vec_y <= y;
    in_vec_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rotated_q.push_back(rotate_vector(cmd, x, y, z));
    if (may_idle && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_random(int count, bit may_idle = 1'b1);
    for (int k = 0; k < count; k++) begin
      send_vector(cmd_e'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                  16'($urandom), may_idle);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_angle(reg_e idx, logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx != REG_UNUSED) begin
      angle_reg[idx] = value;
      rebuild_matrix();
    end
  endtask

  task automatic set_angles(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3);
    write_angle(REG_ANGLE_FIRST, a1);
    write_angle(REG_ANGLE_SECOND, a2);
    write_angle(REG_ANGLE_THIRD, a3);
  endtask

  // Zero angles give the identity; extreme components exercise saturation-free paths.
  task automatic test_reset_angles();
    send_vector(CMD_FORWARD, 16'sh7FFF, -16'sh8000, 16'sh0000);
    send_vector(CMD_BACKWARD, -16'sh8000, 16'sh7FFF, -16'sh8000);
    send_vector(CMD_FORWARD, 16'sh0000, 16'sh0000, 16'sh7FFF);
  endtask

  task automatic test_extreme_angles();
    set_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_vector(CMD_FORWARD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_vector(CMD_BACKWARD, -16'sh8000, -16'sh8000, -16'sh8000);
    set_angles(16'h2000, 16'h2000, 16'h2000);
    send_vector(CMD_FORWARD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_vector(CMD_BACKWARD, -16'sh8000, -16'sh8000, -16'sh8000);
    set_angles(16'h4000, 16'h8000, 16'hC000);
    send_vector(CMD_FORWARD, 16'sh1234, -16'sh4321, 16'sh7FFF);
    send_vector(CMD_BACKWARD, 16'sh1234, -16'sh4321, 16'sh7FFF);
  endtask

  // A write to the unused index must leave the angles untouched.
  task automatic test_unused_index();
    write_angle(REG_UNUSED, 16'h5A5A);
    send_vector(CMD_FORWARD, 16'sh4000, 16'sh2000, -16'sh1000);
    send_vector(CMD_BACKWARD, 16'sh4000, 16'sh2000, -16'sh1000);
  endtask

  task automatic test_random_angles();
    for (int phase = 0; phase < 16; phase++) begin
      set_angles(16'($urandom), 16'($urandom), 16'($urandom));
      send_random(100);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    send_random(40, 1'b0);
  endtask

  task automatic test_streaming();
    drain();
    quiet = 1'b1;
    set_angles(16'($urandom), 16'($urandom), 16'($urandom));
    send_random(200, 1'b0);
  endtask

  initial begin
    int wait_cycles;
    for (int k = 0; k <= N_SINE; k++) begin
      quarter_sine[k] = $rtoi($sin(1.5707963267948966 * k / N_SINE) * 32768.0 + 0.5);
      if (quarter_sine[k] > 32768) quarter_sine[k] = 32768;
    end
    for (int k = 0; k < 3; k++) angle_reg[k] = '0;
    rebuild_matrix();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_angles();
    test_extreme_angles();
    test_unused_index();
    test_random_angles();
    test_backpressure();
    test_streaming();
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (rotated_q.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("euler_angle_vector_rotation regression: pass");
    end else begin
      if (rotated_q.size() != 0) $display("%0d results never arrived", rotated_q.size());
      $display("euler_angle_vector_rotation regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout waiting for the block");
    $display("euler_angle_vector_rotation regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
